FILE: sv/tobe_pkg.sv
`default_nettype none
package tobe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 17;
  localparam int IW        = 32;
  localparam int OUT_BITS  = 26;
  localparam int NORM_BITS = 29;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);

  typedef logic signed [IW-1:0] tobe_word_t;

  localparam tobe_word_t ONE = tobe_word_t'(64'd1 << FRAC_BITS);

  typedef enum logic [1:0] {
    ACT_VALUE = 2'd0,
    ACT_DX    = 2'd1,
    ACT_DY    = 2'd2,
    ACT_NONE  = 2'd3
  } tobe_act_t;

  typedef struct packed {
    logic            live;
    tobe_act_t       action;
    logic [3:0]      idx;
    logic [CW-1:0]   xi;
    logic [CW-1:0]   eta;
  } tobe_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tobe_qstat_t;

  function automatic tobe_word_t mq(input tobe_word_t a, input tobe_word_t b);
    logic signed [2*IW-1:0] pr;
    logic        [2*IW-1:0] mag;
    logic                   neg;
    pr  = a * b;
    neg = pr[2*IW-1];
    mag = neg ? (2*IW)'(-pr) : (2*IW)'(pr);
    mag = (mag + ((2*IW)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return neg ? tobe_word_t'(-mag[IW-1:0]) : tobe_word_t'(mag[IW-1:0]);
  endfunction

  function automatic logic [63:0] norm_const(input logic [63:0] n);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bt;
    v  = n << (2 * NORM_BITS);
    r  = 64'd0;
    bt = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bt > v) bt = bt >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bt != 64'd0) begin
        if (v >= r + bt) begin
          v = v - (r + bt);
          r = (r >> 1) + bt;
        end else begin
          r = r >> 1;
        end
        bt = bt >> 2;
      end
    end
    if (v > r) r = r + 64'd1;
    return r;
  endfunction

  localparam logic [63:0] NK0 = norm_const(64'd1);
  localparam logic [63:0] NK1 = norm_const(64'd2);
  localparam logic [63:0] NK2 = norm_const(64'd6);
  localparam logic [63:0] NK3 = norm_const(64'd3);
  localparam logic [63:0] NK4 = norm_const(64'd9);
  localparam logic [63:0] NK5 = norm_const(64'd15);
  localparam logic [63:0] NK6 = norm_const(64'd4);
  localparam logic [63:0] NK7 = norm_const(64'd12);
  localparam logic [63:0] NK8 = norm_const(64'd20);
  localparam logic [63:0] NK9 = norm_const(64'd28);

endpackage
`default_nettype wire

FILE: sv/tobe_front.sv
`default_nettype none
module tobe_front import tobe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire tobe_act_t  in_action,
  input  wire logic [3:0] in_idx,
  input  wire logic [CW-1:0] in_xi,
  input  wire logic [CW-1:0] in_eta,
  output logic            push,
  output tobe_item_t      push_item,
  input  wire logic       q_full
);

  logic       held;
  tobe_item_t item;

  assign push      = held && !q_full;
  assign in_ready  = !held || !q_full;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.live   <= (in_idx <= 4'd9) && (in_action != ACT_NONE);
      item.action <= in_action;
      item.idx    <= in_idx;
      item.xi     <= in_xi;
      item.eta    <= in_eta;
    end
  end

endmodule
`default_nettype wire

FILE: sv/tobe_queue.sv
`default_nettype none
module tobe_queue import tobe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire tobe_item_t push_item,
  input  wire logic       pop,
  output tobe_item_t      head,
  output tobe_qstat_t     stat
);

  tobe_item_t   mem [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;

  assign head       = mem[rptr];
  assign stat.full  = (count == (QAW+1)'(QDEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + QAW'(1);
      if (pop)  rptr <= rptr + QAW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/tobe_back.sv
`default_nettype none
module tobe_back import tobe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  wire tobe_item_t q_item,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic signed [OUT_BITS-1:0] out_value,
  output logic            out_sat
);

  localparam logic signed [63:0] HI = (64'sd1 <<< (OUT_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] LO = -(64'sd1 <<< (OUT_BITS - 1));

  logic en;
  assign en  = !out_valid || out_ready;
  assign pop = en && q_valid;

  logic       v1, v2, v3, v4, v5;
  tobe_item_t s1, s2, s3;
  tobe_word_t m1, q1, m1_next, q1_next;
  tobe_word_t m1b, q1b, m2, z, m2_next, z_next;
  tobe_word_t p, p_next;
  logic [31:0] kk, kk_next;
  logic signed [63:0] prod;
  logic signed [64:0] pk;

  tobe_word_t x1, y1, u1, w1, a1, b1, bq;
  always_comb begin
    x1 = tobe_word_t'({{(IW-CW){1'b0}}, s1.xi});
    y1 = tobe_word_t'({{(IW-CW){1'b0}}, s1.eta});
    u1 = x1 - ONE;
    w1 = x1 + 2 * y1 - ONE;
    a1 = '0;
    b1 = '0;
    bq = y1;
    unique case (s1.action)
      ACT_VALUE: begin
        unique case (s1.idx)
          4'd3:       begin a1 = 10 * x1 - 8 * ONE;  b1 = x1; end
          4'd4:       begin a1 = 5 * x1 - ONE;       b1 = w1; end
          4'd5, 4'd8: begin a1 = u1;                 b1 = u1 + 6 * y1; end
          4'd6:       begin a1 = 35 * x1 - 45 * ONE; b1 = x1; end
          4'd7:       begin a1 = 21 * x1 - 12 * ONE; b1 = x1; end
          4'd9:       begin a1 = u1 + 12 * y1;       b1 = u1; end
          default:    begin a1 = '0;                 b1 = '0; end
        endcase
      end
      ACT_DX: begin
        unique case (s1.idx)
          4'd6:    begin a1 = 105 * x1 - 90 * ONE;           b1 = x1; end
          4'd7:    begin a1 = 63 * x1 + 84 * y1 - 66 * ONE;  b1 = x1; end
          4'd8:    begin
            a1 = 21 * x1 + 84 * y1 - 30 * ONE;
            b1 = x1;
            bq = 42 * y1 - 48 * ONE;
          end
          4'd9:    begin a1 = u1; b1 = u1 + 8 * y1; end
          default: begin a1 = '0; b1 = '0; end
        endcase
      end
      ACT_DY: begin
        unique case (s1.idx)
          4'd7:    begin a1 = 42 * x1 - 24 * ONE; b1 = x1; end
          4'd8:    begin a1 = 42 * x1 - 6 * ONE;  b1 = w1; end
          4'd9:    begin a1 = u1;                 b1 = u1 + 5 * y1; end
          default: begin a1 = '0;                 b1 = '0; end
        endcase
      end
      default: begin a1 = '0; b1 = '0; end
    endcase
    m1_next = mq(a1, b1);
    q1_next = mq(y1, bq);
  end

  tobe_word_t x2, y2, u2, w2, a2, b2;
  always_comb begin
    x2 = tobe_word_t'({{(IW-CW){1'b0}}, s2.xi});
    y2 = tobe_word_t'({{(IW-CW){1'b0}}, s2.eta});
    u2 = x2 - ONE;
    w2 = x2 + 2 * y2 - ONE;
    a2 = '0;
    b2 = '0;
    if (s2.action == ACT_VALUE) begin
      unique case (s2.idx)
        4'd6:    begin a2 = m1 + 15 * ONE;   b2 = x2; end
        4'd7:    begin a2 = m1 + ONE;        b2 = w2; end
        4'd8:    begin a2 = 7 * x2 - ONE;    b2 = m1 + 6 * q1; end
        4'd9:    begin a2 = m1 + 30 * q1;    b2 = u2; end
        default: begin a2 = '0;              b2 = '0; end
      endcase
    end
    m2_next = mq(a2, b2);
    z_next  = mq(y2, q1);
  end

  tobe_word_t x3, y3, w3;
  always_comb begin
    x3 = tobe_word_t'({{(IW-CW){1'b0}}, s3.xi});
    y3 = tobe_word_t'({{(IW-CW){1'b0}}, s3.eta});
    w3 = x3 + 2 * y3 - ONE;
    p_next = '0;
    unique case (s3.action)
      ACT_VALUE: begin
        unique case (s3.idx)
          4'd0:       p_next = ONE;
          4'd1:       p_next = 3 * x3 - ONE;
          4'd2:       p_next = w3;
          4'd3:       p_next = m1b + ONE;
          4'd4:       p_next = m1b;
          4'd5:       p_next = m1b + 6 * q1b;
          4'd6:       p_next = m2 - ONE;
          4'd7, 4'd8: p_next = m2;
          4'd9:       p_next = m2 + 20 * z;
          default:    p_next = '0;
        endcase
      end
      ACT_DX: begin
        unique case (s3.idx)
          4'd1:    p_next = 3 * ONE;
          4'd2:    p_next = ONE;
          4'd3:    p_next = 20 * x3 - 8 * ONE;
          4'd4:    p_next = 10 * (x3 + y3) - 6 * ONE;
          4'd5:    p_next = 2 * x3 + 6 * y3 - 2 * ONE;
          4'd6:    p_next = m1b + 15 * ONE;
          4'd7:    p_next = m1b - 24 * y3 + 13 * ONE;
          4'd8:    p_next = m1b + q1b + 9 * ONE;
          4'd9:    p_next = 3 * (m1b + 10 * q1b);
          default: p_next = '0;
        endcase
      end
      ACT_DY: begin
        unique case (s3.idx)
          4'd2:    p_next = 2 * ONE;
          4'd4:    p_next = 10 * x3 - 2 * ONE;
          4'd5:    p_next = 6 * w3;
          4'd7:    p_next = m1b + 2 * ONE;
          4'd8:    p_next = m1b;
          4'd9:    p_next = 12 * (m1b + 5 * q1b);
          default: p_next = '0;
        endcase
      end
      default: p_next = '0;
    endcase
    if (!s3.live) p_next = '0;
    unique case (s3.idx)
      4'd0:    kk_next = NK0[31:0];
      4'd1:    kk_next = NK1[31:0];
      4'd2:    kk_next = NK2[31:0];
      4'd3:    kk_next = NK3[31:0];
      4'd4:    kk_next = NK4[31:0];
      4'd5:    kk_next = NK5[31:0];
      4'd6:    kk_next = NK6[31:0];
      4'd7:    kk_next = NK7[31:0];
      4'd8:    kk_next = NK8[31:0];
      4'd9:    kk_next = NK9[31:0];
      default: kk_next = 32'd0;
    endcase
  end

  assign pk = p * $signed({1'b0, kk});

  logic               neg;
  logic        [63:0] mag;
  logic        [63:0] rnd;
  logic signed [63:0] v;
  always_comb begin
    neg = prod[63];
    mag = neg ? 64'(-prod) : 64'(prod);
    rnd = (mag + (64'd1 << (NORM_BITS - 1))) >> NORM_BITS;
    v   = neg ? -$signed(rnd) : $signed(rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1   <= q_item;
      s2   <= s1;
      m1   <= m1_next;
      q1   <= q1_next;
      s3   <= s2;
      m1b  <= m1;
      q1b  <= q1;
      m2   <= m2_next;
      z    <= z_next;
      p    <= p_next;
      kk   <= kk_next;
      prod <= pk[63:0];
      if (v > HI) begin
        out_value <= HI[OUT_BITS-1:0];
        out_sat   <= 1'b1;
      end else if (v < LO) begin
        out_value <= LO[OUT_BITS-1:0];
        out_sat   <= 1'b1;
      end else begin
        out_value <= v[OUT_BITS-1:0];
        out_sat   <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/triangle_orthonormal_basis_eval.sv
// Cubic orthonormal triangle basis evaluator.
// Input stream s_*: one request names a basis function (0..9), an action
// (value, d/dxi, d/deta) and a point (xi, eta) in unsigned Q1.16.
// Output stream m_*: one result per request, in request order, as signed
// Q9.16 with a flag set when the value was clipped to the output range.
// Unknown index or action three returns zero, flag clear.
// A front register takes requests and classifies them, a four-entry queue
// decouples it from a six-stage arithmetic pipeline (operand register, two
// multiply levels of the polynomial, sum, normalisation multiply, rounding
// and clipping).
// Throughput: one request per cycle while the output is not stalled.
// While m_tvalid is high and m_tready low the pipeline holds; the queue then fills and
// s_tready drops once it and the front register are full.
// Synchronous reset empties the queue and the pipeline; no result is
// pending afterwards.
`default_nettype none
module triangle_orthonormal_basis_eval import tobe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // basis_index[3:0], xi[20:4], eta[37:21], zero fill
  input  wire logic [1:0]  s_tuser,  // action[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // basis_value[25:0], zero fill
  output logic [0:0]       m_tuser   // saturated[0]
);

  logic        push;
  tobe_item_t  push_item;
  tobe_item_t  head;
  tobe_qstat_t qstat;
  logic        pop;
  logic signed [OUT_BITS-1:0] value;
  logic        sat;

  tobe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (tobe_act_t'(s_tuser)),
    .in_idx    (s_tdata[3:0]),
    .in_xi     (s_tdata[20:4]),
    .in_eta    (s_tdata[37:21]),
    .push      (push),
    .push_item (push_item),
    .q_full    (qstat.full)
  );

  tobe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  tobe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!qstat.empty),
    .q_item    (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (value),
    .out_sat   (sat)
  );

  assign m_tdata = {{(32-OUT_BITS){1'b0}}, value};
  assign m_tuser = sat;

  a_qstat: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty at once");

  a_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |->
      (m_tdata[25:0] == 26'h1FFFFFF || m_tdata[25:0] == 26'h2000000))
    else $error("saturated flag without clipped value");

  a_push: assert property (@(posedge clk) disable iff (rst)
    (qstat.full && !pop) |=> !($past(push)) || qstat.full)
    else $error("queue lost full state");

endmodule
`default_nettype wire
